@@ design/fxalu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types and constants of the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W = 32;
  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int DIV_STAGES = (NUM_W + 1) / 2;
  localparam int QUO_W = 2 * DIV_STAGES;
  localparam int LATENCY = DIV_STAGES + 2;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_EQ       = 4'd4,
    OP_NE       = 4'd5,
    OP_LT       = 4'd6,
    OP_GT       = 4'd7,
    OP_LE       = 4'd8,
    OP_GE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               flag;
    logic               div_by_zero;
  } rsp_t;

  typedef struct packed {
    logic               vld;
    op_t                op;
    logic [31:0]        res;
    logic               flag;
    logic               dz;
    logic signed [63:0] prod;
    logic               neg;
    logic [QUO_W-1:0]   quo;
    logic [31:0]        rem;
    logic [31:0]        dvs;
  } pipe_t;

endpackage : fxalu_pkg
`default_nettype wire

@@ design/fxalu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fxalu_front
// First stage: simple operations, full product and divider operand setup.
// ----------------------------------------------------------------------------
module fxalu_front
  import fxalu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  vld_in,
  input  wire cmd_t  cmd,
  output pipe_t      st
);

  pipe_t st_next;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [31:0] a_mag;
  logic [31:0] b_mag;

  always_comb begin
    a = cmd.operand_a;
    b = cmd.operand_b;
    a_mag = a[31] ? 32'(-a) : a;
    b_mag = b[31] ? 32'(-b) : b;
    st_next = '0;
    st_next.vld = vld_in;
    st_next.op = cmd.op;
    st_next.prod = 64'(a) * 64'(b);
    st_next.neg = a[31] ^ b[31];
    st_next.quo = QUO_W'({a_mag, {FRAC_BITS{1'b0}}});
    st_next.rem = '0;
    st_next.dvs = b_mag;
    case (cmd.op)
      OP_ADD:      st_next.res = a + b;
      OP_SUB:      st_next.res = a - b;
      OP_DIV:      st_next.dz = (b == 32'sd0);
      OP_EQ:       st_next.flag = (a == b);
      OP_NE:       st_next.flag = (a != b);
      OP_LT:       st_next.flag = (a < b);
      OP_GT:       st_next.flag = (a > b);
      OP_LE:       st_next.flag = (a <= b);
      OP_GE:       st_next.flag = (a >= b);
      OP_MIN:      st_next.res = (a <= b) ? a : b;
      OP_MAX:      st_next.res = (a >= b) ? a : b;
      OP_INC:      st_next.res = a + 32'sd1;
      OP_DEC:      st_next.res = a - 32'sd1;
      OP_FROM_INT: st_next.res = a << FRAC_BITS;
      OP_TO_INT:   st_next.res = a >>> FRAC_BITS;
      default:     st_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule : fxalu_front
`default_nettype wire

@@ design/fxalu_div_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fxalu_div_stage
// One divider stage: two restoring quotient bits, payload carried along.
// ----------------------------------------------------------------------------
module fxalu_div_stage
  import fxalu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire pipe_t st_in,
  output pipe_t      st_out
);

  pipe_t st_next;
  logic [32:0] trial;

  always_comb begin
    st_next = st_in;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {st_next.rem, st_next.quo[QUO_W-1]};
      if (trial >= {1'b0, st_next.dvs}) begin
        trial = trial - {1'b0, st_next.dvs};
        st_next.quo = {st_next.quo[QUO_W-2:0], 1'b1};
      end else begin
        st_next.quo = {st_next.quo[QUO_W-2:0], 1'b0};
      end
      st_next.rem = trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out <= '0;
    end else begin
      st_out <= st_next;
    end
  end

endmodule : fxalu_div_stage
`default_nettype wire

@@ design/fxalu_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fxalu_back
// Last stage: product scaling, quotient sign and result selection.
// ----------------------------------------------------------------------------
module fxalu_back
  import fxalu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire pipe_t st,
  output logic       done,
  output rsp_t       rsp
);

  rsp_t rsp_next;
  logic [31:0] q;

  always_comb begin
    q = st.quo[31:0];
    rsp_next.flag = st.flag;
    rsp_next.div_by_zero = st.dz;
    case (st.op)
      OP_MUL:  rsp_next.result = st.prod[FRAC_BITS +: 32];
      OP_DIV:  rsp_next.result = st.dz ? '0 : (st.neg ? 32'(-q) : q);
      default: rsp_next.result = st.res;
    endcase
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st.vld;
    end
  end

endmodule : fxalu_back
`default_nettype wire

@@ design/fixed_point_q24_8_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Pipelined signed fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Takes one transaction every cycle; busy stays low. Every result appears on
// response with done high after the front register, the DIV_STAGES divider
// stages and the back register, in issue order, for one cycle only: the
// receiver cannot hold results off. The pipeline depth is set by the divider, which
// resolves two quotient bits per stage over 32 + FRAC_BITS bits; all
// operations travel the same path.
module fixed_point_q24_8_alu
  import fxalu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t command,
  output logic      done,
  output rsp_t      response
);

  pipe_t st [DIV_STAGES+1];

  assign busy = 1'b0;

  fxalu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .vld_in (start),
    .cmd    (command),
    .st     (st[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fxalu_div_stage u_stage (
      .clk    (clk),
      .rst    (rst),
      .st_in  (st[g]),
      .st_out (st[g+1])
    );
  end

  fxalu_back u_back (
    .clk  (clk),
    .rst  (rst),
    .st   (st[DIV_STAGES]),
    .done (done),
    .rsp  (response)
  );

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a transaction");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && response.div_by_zero) |-> (response.result == '0 && !response.flag))
    else $error("divide by zero result not cleared");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (done && response.flag) |-> (response.result == '0 && !response.div_by_zero))
    else $error("comparison result not zero");

endmodule : fixed_point_q24_8_alu
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pipelined fixed-point ALU against a behavioral predictor, with a
// directed table of edge cases followed by random operations with and without idling.
// ----------------------------------------------------------------------------
module testbench;
  import fxalu_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    bit          known;
    rsp_t        rsp;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t command;
  logic done;
  rsp_t response;

  rsp_t  pending_rsps[$];
  int    mismatches;
  int    cycles;
  int    sent;
  int    checked;
  int    idle_pct;
  int    op_hits[16];
  row_t  rows[$];

  fixed_point_q24_8_alu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .done(done), .response(response)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic rsp_t alu_compute(op_t op, logic [31:0] ua, logic [31:0] ub);
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] wide;
    logic signed [63:0] num;
    rsp_t r;
    a = ua;
    b = ub;
    r = '0;
    case (op)
      OP_ADD: r.result = ua + ub;
      OP_SUB: r.result = ua - ub;
      OP_MUL: begin
        wide = 64'(a) * 64'(b);
        wide = wide >>> FRAC_BITS;
        r.result = wide[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          num = 64'(a) <<< FRAC_BITS;
          wide = num / 64'(b);
          r.result = wide[31:0];
        end
      end
      OP_EQ: r.flag = (a == b);
      OP_NE: r.flag = (a != b);
      OP_LT: r.flag = (a < b);
      OP_GT: r.flag = (a > b);
      OP_LE: r.flag = (a <= b);
      OP_GE: r.flag = (a >= b);
      OP_MIN: r.result = (a <= b) ? ua : ub;
      OP_MAX: r.result = (a >= b) ? ua : ub;
      OP_INC: r.result = ua + 32'd1;
      OP_DEC: r.result = ua - 32'd1;
      OP_FROM_INT: r.result = ua << FRAC_BITS;
      default: r.result = a >>> FRAC_BITS;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return 32'($urandom_range(0, 2047)) << $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(op_t op, logic [31:0] a, logic [31:0] b, bit known, rsp_t rsp);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    command <= '{op: op, operand_a: a, operand_b: b};
    do @(posedge clk); while (busy);
    pending_rsps.push_back(known ? rsp : alu_compute(op, a, b));
    sent++;
    op_hits[op]++;
    @(negedge clk);
  endtask

  function automatic rsp_t mk(logic [31:0] r, logic f, logic z);
    rsp_t x;
    x.result = r;
    x.flag = f;
    x.div_by_zero = z;
    return x;
  endfunction

  function automatic void add_row(op_t op, logic [31:0] a, logic [31:0] b, bit known,
                                  rsp_t rsp);
    rows.push_back('{op: op, a: a, b: b, known: known, rsp: rsp});
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    cycles++;
    if (!rst && done) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: result %h flag %b dz %b",
                   response.result, response.flag, response.div_by_zero);
      end else begin
        want = pending_rsps.pop_front();
        checked++;
        if (response.result !== want.result || response.flag !== want.flag ||
            response.div_by_zero !== want.div_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", want.result, want.flag,
                     want.div_by_zero, response.result, response.flag,
                     response.div_by_zero);
        end
      end
    end
    if (cycles > 200000) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    command = '0;
    mismatches = 0;
    cycles = 0;
    sent = 0;
    checked = 0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(OP_ADD, 32'h7fff_ffff, 32'd1, 1, mk(32'h8000_0000, 0, 0));
    add_row(OP_SUB, 32'h8000_0000, 32'd1, 1, mk(32'h7fff_ffff, 0, 0));
    add_row(OP_MUL, 32'h0000_0100, 32'h0000_0100, 1, mk(32'h0000_0100, 0, 0));
    add_row(OP_MUL, 32'hffff_ffff, 32'd1, 1, mk(32'hffff_ffff, 0, 0));
    add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0);
    add_row(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 0, '0);
    add_row(OP_DIV, 32'h0000_0100, 32'd0, 1, mk(32'd0, 0, 1));
    add_row(OP_DIV, 32'h8000_0000, 32'd0, 1, mk(32'd0, 0, 1));
    add_row(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0, '0);
    add_row(OP_DIV, 32'h7fff_ffff, 32'd1, 0, '0);
    add_row(OP_DIV, 32'hffff_ff00, 32'h0000_0300, 0, '0);
    add_row(OP_EQ, 32'h8000_0000, 32'h8000_0000, 1, mk(32'd0, 1, 0));
    add_row(OP_NE, 32'h7fff_ffff, 32'h8000_0000, 1, mk(32'd0, 1, 0));
    add_row(OP_LT, 32'h8000_0000, 32'h7fff_ffff, 1, mk(32'd0, 1, 0));
    add_row(OP_GT, 32'd5, 32'd5, 1, mk(32'd0, 0, 0));
    add_row(OP_GT, 32'h7fff_ffff, 32'h8000_0000, 1, mk(32'd0, 1, 0));
    add_row(OP_LE, 32'd5, 32'd5, 1, mk(32'd0, 1, 0));
    add_row(OP_GE, 32'h8000_0000, 32'd0, 1, mk(32'd0, 0, 0));
    add_row(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 1, mk(32'h8000_0000, 0, 0));
    add_row(OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 1, mk(32'h7fff_ffff, 0, 0));
    add_row(OP_INC, 32'h7fff_ffff, 32'hffff_ffff, 1, mk(32'h8000_0000, 0, 0));
    add_row(OP_DEC, 32'h8000_0000, 32'hffff_ffff, 1, mk(32'h7fff_ffff, 0, 0));
    add_row(OP_FROM_INT, 32'hffff_ffff, 32'd0, 1, mk(32'hffff_ff00, 0, 0));
    add_row(OP_TO_INT, 32'hffff_ffff, 32'd0, 1, mk(32'hffff_ffff, 0, 0));
    add_row(OP_TO_INT, 32'h7fff_ffff, 32'd0, 1, mk(32'h007f_ffff, 0, 0));

    foreach (rows[i]) issue(rows[i].op, rows[i].a, rows[i].b, rows[i].known, rows[i].rsp);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 28 : (phase == 1) ? 77 : 0;
      for (n = 0; n < 330; n++)
        issue(op_t'($urandom_range(0, 15)), random_operand(),
              ($urandom_range(0, 15) == 0) ? 32'd0 : random_operand(), 0, '0);
    end
    start <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("sent %0d transactions, checked %0d results", sent, checked);
    $display("div %0d, mul %0d, to_int %0d transactions among the sixteen ops",
             op_hits[OP_DIV], op_hits[OP_MUL], op_hits[OP_TO_INT]);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
